### sv/update_rate_liveness_monitor_top_macros.svh
// Assertion macros for the update-rate liveness monitor
`ifndef UPDATE_RATE_LIVENESS_MONITOR_TOP_MACROS_SVH
`define UPDATE_RATE_LIVENESS_MONITOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define URLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define URLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define URLM_ASSERT(lbl, prop, msg)
`define URLM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/urlm_pkg.sv
package urlm_pkg;

  localparam int unsigned TIME_BITS         = 48;
  localparam int unsigned DEF_COUNT_BITS    = 32;
  localparam int unsigned WIN_COUNT_BITS    = 32;
  localparam int unsigned STAT_BITS         = 32;
  localparam int unsigned AGE_BITS          = TIME_BITS + 1;
  localparam int unsigned OP_BITS           = 2;
  localparam int unsigned CFG_IDX_BITS      = 1;
  localparam int unsigned CFG_DATA_BITS     = 48;
  localparam int unsigned NUM_BITS          = 64;
  localparam int unsigned DIV_CNT_BITS      = $clog2(NUM_BITS);
  localparam int unsigned SCALE_BITS        = 30;
  localparam int unsigned PROD_BITS         = WIN_COUNT_BITS + SCALE_BITS;
  localparam int unsigned IN_TDATA_BITS     = 48;
  localparam int unsigned OUT_TDATA_BITS    = 184;

  localparam logic [SCALE_BITS-1:0] MILLIHZ_SCALE   = 30'd1000000000;
  localparam logic [31:0]           WINDOW_US_RESET = 32'd1000000;
  localparam logic [47:0]           MAX_AGE_RESET   = 48'd100000;

  typedef enum logic [OP_BITS-1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_US  = 1'd0,
    CFG_MAX_AGE_US = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic div_init;
    logic div_step;
    logic publish;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_update;
    logic publish;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

### sv/update_rate_liveness_monitor_top.sv
// Path: a query, clear or update that closes no window goes from capture through the exec
// state to the result register; an update that closes a window first passes a multiply
// state, an add state, the bit-serial 64-step rate divider and a publish state.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: rst_ni is asynchronous, active low; it zeroes all statistics and loads the window
// and max-age registers with 1000000 us and 100000 us.
module update_rate_liveness_monitor_top #(
  parameter int unsigned COUNT_BITS = urlm_pkg::DEF_COUNT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // now_us[47:0]
  input  logic [urlm_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [urlm_pkg::OP_BITS-1:0]         s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // live_valid[0], update_count[32:1], rate_millihz[64:33], recent_gap[96:65],
  // window_max_gap[128:97], age_us[177:129], active[178], zero[183:179]
  output logic [urlm_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [urlm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [urlm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import urlm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  urlm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  urlm_dp #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

endmodule

### sv/urlm_div.sv
module urlm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               step_i,
  input  logic [urlm_pkg::NUM_BITS-1:0]      num_i,
  input  logic [urlm_pkg::TIME_BITS-1:0]     den_i,
  output logic [urlm_pkg::NUM_BITS-1:0]      quo_o,
  output logic                               last_o
);
  import urlm_pkg::*;

  logic [NUM_BITS-1:0]     num_q, num_d;
  logic [TIME_BITS-1:0]    rem_q, rem_d;
  logic [TIME_BITS-1:0]    den_q;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [TIME_BITS:0]      shifted;
  logic                    ge;

  always_comb begin
    shifted = {rem_q, num_q[NUM_BITS-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? TIME_BITS'(shifted - {1'b0, den_q}) : shifted[TIME_BITS-1:0];
    num_d   = {num_q[NUM_BITS-2:0], ge};
    cnt_d   = cnt_q + DIV_CNT_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (step_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = num_q;
  assign last_o = &cnt_q;

endmodule

### sv/urlm_ctrl.sv
`include "update_rate_liveness_monitor_top_macros.svh"

module urlm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  urlm_pkg::dp_status_t status_i,
  output urlm_pkg::dp_cmd_t    cmd_o
);
  import urlm_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_ADD  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_PUB  = 7'b0100000,
    ST_RESP = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = s_axis_tvalid;
        if (s_axis_tvalid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = (status_i.is_update && status_i.publish) ? ST_MUL : ST_RESP;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_PUB;
      end
      ST_PUB: begin
        cmd_o.publish = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.load_out = status_i.out_free;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  `URLM_ASSERT_NEXT(a_div_to_pub, state_q == ST_DIV && status_i.div_last, state_q == ST_PUB, "divider did not hand over to publish")
  `URLM_ASSERT_NEXT(a_plain_op_short, state_q == ST_EXEC && !status_i.is_update, state_q == ST_RESP, "non-update item entered the rate path")
  `URLM_ASSERT(a_load_when_free, cmd_o.load_out |-> status_i.out_free, "result loaded over a waiting beat")

endmodule

### sv/urlm_dp.sv
`include "update_rate_liveness_monitor_top_macros.svh"

module urlm_dp #(
  parameter int unsigned COUNT_BITS = urlm_pkg::DEF_COUNT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  urlm_pkg::dp_cmd_t                    cmd_i,
  output urlm_pkg::dp_status_t                 status_o,
  input  logic [urlm_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  input  logic [urlm_pkg::OP_BITS-1:0]         s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [urlm_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [urlm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [urlm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import urlm_pkg::*;

  logic [31:0]               window_q;
  logic [47:0]               max_age_q;
  op_e                       op_q;
  logic [TIME_BITS-1:0]      now_q;

  logic                      valid_q;
  logic [COUNT_BITS-1:0]     total_q;
  logic [TIME_BITS-1:0]      last_q;
  logic [STAT_BITS-1:0]      rate_q;
  logic [STAT_BITS-1:0]      gap_q;
  logic [STAT_BITS-1:0]      max_gap_q;
  logic [WIN_COUNT_BITS-1:0] win_count_q;
  logic [STAT_BITS-1:0]      peak_q;
  logic [TIME_BITS-1:0]      win_start_q;
  logic [TIME_BITS-1:0]      elapsed_q;
  logic [PROD_BITS-1:0]      prod_q;

  logic [TIME_BITS-1:0]      win_start_new;
  logic [TIME_BITS-1:0]      elapsed;
  logic [31:0]               win_eff;
  logic [TIME_BITS-1:0]      gap_raw;
  logic [STAT_BITS-1:0]      gap_sat;
  logic                      gap_ok;
  logic [NUM_BITS-1:0]       div_num;
  logic [NUM_BITS-1:0]       quo;
  logic                      div_last;
  logic [STAT_BITS-1:0]      rate_sat;
  logic [AGE_BITS-1:0]       diff;
  logic [AGE_BITS-1:0]       age;
  logic                      active;
  logic                      out_valid_q;
  logic [OUT_TDATA_BITS-1:0] out_data_q;

  always_comb begin
    win_start_new = (win_start_q == '0) ? now_q : win_start_q;
    elapsed       = now_q - win_start_new;
    win_eff       = (window_q == '0) ? 32'd1 : window_q;
    gap_raw       = now_q - last_q;
    gap_sat       = (|gap_raw[TIME_BITS-1:STAT_BITS]) ? '1 : gap_raw[STAT_BITS-1:0];
    gap_ok        = (last_q != '0) && (now_q > last_q);
    div_num       = NUM_BITS'(prod_q) + NUM_BITS'(elapsed_q >> 1);
    rate_sat      = (|quo[NUM_BITS-1:STAT_BITS]) ? '1 : quo[STAT_BITS-1:0];
    diff          = {1'b0, now_q} - {1'b0, last_q};
    age           = valid_q ? diff : {1'b0, {TIME_BITS{1'b1}}};
    active        = valid_q && (diff[AGE_BITS-1] || (diff[TIME_BITS-1:0] <= max_age_q));
  end

  assign status_o.is_update = (op_q == OP_UPDATE);
  assign status_o.publish   = (now_q >= win_start_new) &&
                              (elapsed >= {{(TIME_BITS-32){1'b0}}, win_eff});
  assign status_o.div_last  = div_last;
  assign status_o.out_free  = !out_valid_q || m_axis_tready;

  urlm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_init),
    .step_i (cmd_i.div_step),
    .num_i  (div_num),
    .den_i  (elapsed_q),
    .quo_o  (quo),
    .last_o (div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WINDOW_US_RESET;
      max_age_q <= MAX_AGE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_US:  window_q  <= cfg_data_i[31:0];
        CFG_MAX_AGE_US: max_age_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(s_axis_tuser);
      now_q <= s_axis_tdata;
    end
    if (cmd_i.exec) begin
      elapsed_q <= elapsed;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_BITS'(win_count_q) * PROD_BITS'(MILLIHZ_SCALE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      total_q     <= '0;
      last_q      <= '0;
      rate_q      <= '0;
      gap_q       <= '0;
      max_gap_q   <= '0;
      win_count_q <= '0;
      peak_q      <= '0;
      win_start_q <= '0;
    end else if (cmd_i.exec) begin
      case (op_q)
        OP_UPDATE: begin
          win_start_q <= win_start_new;
          if (gap_ok) begin
            gap_q <= gap_sat;
            if (gap_sat > peak_q) peak_q <= gap_sat;
          end
          last_q      <= now_q;
          valid_q     <= 1'b1;
          total_q     <= total_q + COUNT_BITS'(1);
          win_count_q <= win_count_q + WIN_COUNT_BITS'(1);
        end
        OP_CLEAR: begin
          valid_q     <= 1'b0;
          total_q     <= '0;
          last_q      <= '0;
          rate_q      <= '0;
          gap_q       <= '0;
          max_gap_q   <= '0;
          win_count_q <= '0;
          peak_q      <= '0;
          win_start_q <= '0;
        end
        default: ;
      endcase
    end else if (cmd_i.publish) begin
      rate_q      <= rate_sat;
      max_gap_q   <= peak_q;
      win_count_q <= '0;
      peak_q      <= '0;
      win_start_q <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {5'b0, active, age, max_gap_q, gap_q, rate_q,
                     STAT_BITS'(total_q), valid_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `URLM_ASSERT(a_invalid_is_empty, !valid_q |-> (last_q == '0 && total_q == '0), "state left behind without a recorded update")
  `URLM_ASSERT_NEXT(a_publish_restarts, cmd_i.publish, (win_count_q == '0 && peak_q == '0), "window not restarted after publish")
  `URLM_ASSERT_NEXT(a_clear_drops_valid, cmd_i.exec && op_q == OP_CLEAR, !valid_q, "clear left the monitor valid")

endmodule

### tb/update_rate_liveness_monitor_checker.sv
`timescale 1ns / 1ps

module update_rate_liveness_monitor_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  // now_us[47:0]
  input  logic [urlm_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [urlm_pkg::OP_BITS-1:0]         s_axis_tuser,
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // live_valid[0], update_count[32:1], rate_millihz[64:33], recent_gap[96:65],
  // window_max_gap[128:97], age_us[177:129], active[178], zero[183:179]
  input  logic [urlm_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [urlm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [urlm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 drain_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);

  import urlm_pkg::*;

  typedef struct packed {
    logic [4:0]  pad;
    logic        active;
    logic [48:0] age_us;
    logic [31:0] window_max_gap;
    logic [31:0] recent_gap;
    logic [31:0] rate_millihz;
    logic [31:0] update_count;
    logic        live_valid;
  } stats_beat_t;

  localparam logic [63:0] MILLIHZ_PER_HZ = 64'd1000000000;
  localparam logic [48:0] AGE_UNSEEN     = {1'b0, {48{1'b1}}};

  logic [31:0] win_len;
  logic [47:0] max_age;
  logic        seen;
  logic [31:0] upd_total;
  logic [47:0] last_time;
  logic [31:0] rate_pub;
  logic [31:0] last_gap;
  logic [31:0] peak_pub;
  logic [31:0] win_updates;
  logic [31:0] win_peak;
  logic [47:0] win_start;

  stats_beat_t stats_due[$];
  stats_beat_t want;
  stats_beat_t got;
  int unsigned beat_no;
  logic        drained;

  task automatic clear_stats();
    seen        = 1'b0;
    upd_total   = '0;
    last_time   = '0;
    rate_pub    = '0;
    last_gap    = '0;
    peak_pub    = '0;
    win_updates = '0;
    win_peak    = '0;
    win_start   = '0;
  endtask

  task automatic record_update(input logic [47:0] now);
    logic [31:0] span;
    logic [47:0] gap;
    logic [31:0] gap_sat;
    logic [47:0] elapsed;
    logic [63:0] quot;
    span = (win_len == '0) ? 32'd1 : win_len;
    if (win_start == '0) begin
      win_start = now;
    end
    if (last_time != '0 && now > last_time) begin
      gap = now - last_time;
      gap_sat = (gap > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
      last_gap = gap_sat;
      if (gap_sat > win_peak) begin
        win_peak = gap_sat;
      end
    end
    last_time   = now;
    seen        = 1'b1;
    upd_total   = upd_total + 32'd1;
    win_updates = win_updates + 32'd1;
    if (now >= win_start) begin
      elapsed = now - win_start;
      if (elapsed >= {16'd0, span}) begin
        quot = ({32'd0, win_updates} * MILLIHZ_PER_HZ + {16'd0, elapsed >> 1})
               / {16'd0, elapsed};
        rate_pub    = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        peak_pub    = win_peak;
        win_updates = '0;
        win_peak    = '0;
        win_start   = now;
      end
    end
  endtask

  task automatic apply_item(input logic [1:0] op, input logic [47:0] now,
                            output stats_beat_t res);
    logic [47:0] diff;
    if (op == OP_UPDATE) begin
      record_update(now);
    end else if (op == OP_CLEAR) begin
      clear_stats();
    end
    res = '0;
    if (!seen) begin
      res.age_us = AGE_UNSEEN;
      res.active = 1'b0;
    end else if (now >= last_time) begin
      diff = now - last_time;
      res.age_us = {1'b0, diff};
      res.active = (diff <= max_age);
    end else begin
      diff = last_time - now;
      res.age_us = 49'd0 - {1'b0, diff};
      res.active = 1'b1;
    end
    res.live_valid     = seen;
    res.update_count   = upd_total;
    res.rate_millihz   = rate_pub;
    res.recent_gap     = last_gap;
    res.window_max_gap = peak_pub;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] seen_val,
                               input logic [63:0] want_val);
    $display("%0t beat %0d %s: got %0h, expected %0h", $time, beat_no, what,
             seen_val, want_val);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len = WINDOW_US_RESET;
      max_age = MAX_AGE_RESET;
      clear_stats();
      stats_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      beat_no      = 0;
      drained      = 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WINDOW_US) begin
          win_len = cfg_data_i[31:0];
        end else if (cfg_idx_i == CFG_MAX_AGE_US) begin
          max_age = cfg_data_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_item(s_axis_tuser, s_axis_tdata[47:0], want);
        stats_due.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (stats_due.size() == 0) begin
          flag_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
        end else begin
          want = stats_due.pop_front();
          if (got.live_valid !== want.live_valid)
            flag_mismatch("live_valid", 64'(got.live_valid), 64'(want.live_valid));
          if (got.update_count !== want.update_count)
            flag_mismatch("update_count", 64'(got.update_count),
                          64'(want.update_count));
          if (got.rate_millihz !== want.rate_millihz)
            flag_mismatch("rate_millihz", 64'(got.rate_millihz),
                          64'(want.rate_millihz));
          if (got.recent_gap !== want.recent_gap)
            flag_mismatch("recent_gap", 64'(got.recent_gap), 64'(want.recent_gap));
          if (got.window_max_gap !== want.window_max_gap)
            flag_mismatch("window_max_gap", 64'(got.window_max_gap),
                          64'(want.window_max_gap));
          if (got.age_us !== want.age_us)
            flag_mismatch("age_us", 64'(got.age_us), 64'(want.age_us));
          if (got.active !== want.active)
            flag_mismatch("active", 64'(got.active), 64'(want.active));
          if (got.pad !== want.pad)
            flag_mismatch("padding", 64'(got.pad), 64'(want.pad));
        end
        beat_no++;
      end
      if (drain_i && !drained) begin
        drained = 1'b1;
        if (stats_due.size() != 0) begin
          flag_mismatch("results still due", 64'(stats_due.size()), '0);
        end
      end
      pending_o = stats_due.size();
    end
  end

endmodule

### tb/update_rate_liveness_monitor_top_tb.sv
`timescale 1ns / 1ps

module update_rate_liveness_monitor_top_tb;

  import urlm_pkg::*;

  localparam logic [1:0]  OP_RESERVED = 2'd3;
  localparam logic [47:0] TIME_TOP    = {48{1'b1}};
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         s_axis_tvalid  = 1'b0;
  logic                         s_axis_tready;
  logic [IN_TDATA_BITS-1:0]     s_axis_tdata   = '0;
  logic [OP_BITS-1:0]           s_axis_tuser   = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready  = 1'b0;
  logic [OUT_TDATA_BITS-1:0]    m_axis_tdata;
  logic                         cfg_we_i       = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_idx_i      = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data_i     = '0;
  logic                         drain          = 1'b0;
  int unsigned                  fail_count;
  int unsigned                  pending;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycles        = 0;
  logic [47:0] cursor        = '0;
  logic [31:0] win_set       = 32'd1000000;

  update_rate_liveness_monitor_top dut (.*);

  update_rate_liveness_monitor_checker checker_i (
    .drain_i      (drain),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .*
  );

  always #10 clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [47:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] win, input logic [47:0] age_lim);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WINDOW_US;
    cfg_data_i <= {16'd0, win};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_AGE_US;
    cfg_data_i <= age_lim;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    win_set = win;
  endtask

  task automatic send_random();
    logic [47:0] now;
    logic [1:0]  op;
    int unsigned step_top;
    int unsigned pick;
    step_top = (win_set == 0) ? 4 : ((win_set > 1000) ? 2000 : 2 * win_set);
    pick = $urandom_range(0, 99);
    if (pick < 70) op = OP_UPDATE;
    else if (pick < 88) op = OP_QUERY;
    else if (pick < 94) op = OP_CLEAR;
    else op = OP_RESERVED;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      now = cursor - 48'($urandom_range(1, step_top + 10));
    end else if (pick < 6) begin
      cursor = cursor + (48'($urandom_range(1, 7)) << 32) + 48'($urandom);
      now = cursor;
    end else if (pick < 7) begin
      now = '0;
    end else if (pick < 9) begin
      now = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
    end else begin
      cursor = cursor + 48'($urandom_range(0, step_top));
      now = cursor;
    end
    send_item(op, now);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 1 s window, 100 ms age limit
    send_item(OP_QUERY, 48'd5);
    send_item(OP_UPDATE, 48'd0);
    send_item(OP_UPDATE, 48'd100);
    send_item(OP_UPDATE, 48'd300);
    send_item(OP_QUERY, 48'd250);
    send_item(OP_UPDATE, 48'd200);
    send_item(OP_QUERY, 48'd200200);
    send_item(OP_QUERY, 48'd100200);
    send_item(OP_UPDATE, 48'd1000100);
    send_item(OP_UPDATE, 48'd1000100 + (48'd1 << 33));
    send_item(OP_RESERVED, 48'd12345);
    send_item(OP_QUERY, TIME_TOP);
    send_item(OP_CLEAR, 48'd0);
    send_item(OP_QUERY, 48'd7);

    set_config(32'd1, 48'd0);
    send_item(OP_UPDATE, TIME_TOP);
    send_item(OP_QUERY, TIME_TOP);
    send_item(OP_QUERY, TIME_TOP - 48'd1);
    send_item(OP_CLEAR, 48'd0);
    repeat (4) send_item(OP_UPDATE, 48'd10);
    send_item(OP_UPDATE, 48'd11);

    set_config(32'd0, TIME_TOP);
    send_item(OP_UPDATE, 48'd12);
    send_item(OP_QUERY, 48'd0);

    cursor = 48'd1000;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          set_config(32'd50, 48'd200);
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          set_config(32'd1, 48'd0);
          send_idle_pct = 82;
          stall_pct     = 0;
        end
        2: begin
          set_config(32'd0, TIME_TOP);
          send_idle_pct = 0;
          stall_pct     = 82;
          hold_req      = 1'b1;
        end
        3: begin
          set_config(32'hFFFF_FFFF, {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)});
          send_idle_pct = 16;
          stall_pct     = 16;
        end
        default: begin
          set_config(32'($urandom_range(1, 5000)), 48'($urandom_range(0, 10000)));
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random();
      end
    end

    stall_pct = 0;
    settle();
    repeat (80) @(posedge clk_i);
    drain <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
